FILE: rtl/core/bra_pkg.sv
package bra_pkg;

   // Table dimensions and unit width
   localparam int MAX_PROCS = 8;
   localparam int MAX_RES   = 8;
   localparam int UNIT_BITS = 8;

   // Derived widths
   localparam int PROC_IDX_BITS = ($clog2(MAX_PROCS) > 0) ? $clog2(MAX_PROCS) : 1;
   localparam int RES_IDX_BITS  = ($clog2(MAX_RES) > 0) ? $clog2(MAX_RES) : 1;
   localparam int PROC_CNT_BITS = $clog2(MAX_PROCS + 1);
   localparam int RES_CNT_BITS  = $clog2(MAX_RES + 1);
   localparam int WORK_BITS     = UNIT_BITS + $clog2(MAX_PROCS + 1);

   // Port field widths
   localparam int ACTION_BITS    = 3;
   localparam int PROC_FLD_BITS  = 3;
   localparam int RES_FLD_BITS   = 3;
   localparam int AMOUNT_BITS    = 8;
   localparam int STATUS_BITS    = 3;
   localparam int CFG_BITS       = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CFG_RESET      = 8;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_PROCS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_RES   = 2'd1;

   typedef logic [UNIT_BITS-1:0]     unit_type;
   typedef unit_type [MAX_RES-1:0]   unit_vec_type;
   typedef logic [WORK_BITS-1:0]     work_type;
   typedef work_type [MAX_RES-1:0]   work_vec_type;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_LOAD_AVAIL = 3'd0,
      ACT_LOAD_MAX   = 3'd1,
      ACT_LOAD_ALLOC = 3'd2,
      ACT_REQUEST    = 3'd3,
      ACT_SAFETY     = 3'd4
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ACCEPTED = 3'd0,
      ST_GRANTED  = 3'd1,
      ST_EXCEEDS  = 3'd2,
      ST_UNAVAIL  = 3'd3,
      ST_ROLLBACK = 3'd4,
      ST_SAFE     = 3'd5,
      ST_UNSAFE   = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NEED,
      S_AVAIL,
      S_APPLY_AV,
      S_APPLY_AL,
      S_INIT,
      S_SAFE,
      S_UNDO_AV,
      S_UNDO_AL
   } state_type;

   // Compare operand selection of the vector unit
   typedef enum logic [1:0] {
      CMP_LHS_RHS,
      CMP_LHS_NEED,
      CMP_NEED_RHS
   } cmp_sel_type;

   typedef struct packed {
      cmp_sel_type cmp_sel;
      logic        acc_sub;
   } unit_ctl_type;

endpackage

FILE: rtl/core/bankers_resource_allocator_core.sv
// Banker's-algorithm allocator. Each transfer on start gets exactly one status strobe on
// rsp_valid, and the receiver cannot stall it. Table loads, non-final request
// elements and unknown actions answer in the cycle after the transfer, and the next
// item may follow at once. A final request element runs the check against the
// remaining claim, the availability check, the updates of the available and allocation
// tables and the safety scan, and on rollback undoes both updates; a safety check sets
// up the work vector and runs the scan. The scan visits one process per cycle in a shared
// vector compare/add unit and makes at most P passes over P processes. busy is high for
// the whole evaluation and start is ignored meanwhile.
module bankers_resource_allocator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [bra_pkg::ACTION_BITS-1:0]      req_action,
   input  logic [bra_pkg::PROC_FLD_BITS-1:0]    req_process,
   input  logic [bra_pkg::RES_FLD_BITS-1:0]     req_resource,
   input  logic [bra_pkg::AMOUNT_BITS-1:0]      req_amount,
   input  logic                                 req_last_element,
   output logic                                 rsp_valid,
   output logic [bra_pkg::STATUS_BITS-1:0]      rsp_status,
   input  logic                                 csr_write_en,
   input  logic [bra_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bra_pkg::CFG_BITS-1:0]         csr_wdata
);

   bra_pkg::state_type                  state_ff, state_in;
   logic [bra_pkg::CFG_BITS-1:0]        np_cfg_ff, np_cfg_in;
   logic [bra_pkg::CFG_BITS-1:0]        nr_cfg_ff, nr_cfg_in;
   bra_pkg::unit_vec_type               avail_ff, avail_in;
   bra_pkg::unit_vec_type               max_ff [bra_pkg::MAX_PROCS];
   bra_pkg::unit_vec_type               max_in [bra_pkg::MAX_PROCS];
   bra_pkg::unit_vec_type               alloc_ff [bra_pkg::MAX_PROCS];
   bra_pkg::unit_vec_type               alloc_in [bra_pkg::MAX_PROCS];
   bra_pkg::unit_vec_type               pending_ff, pending_in;
   bra_pkg::work_vec_type               work_ff, work_in;
   logic [bra_pkg::MAX_PROCS-1:0]       finished_ff, finished_in;
   logic [bra_pkg::PROC_FLD_BITS-1:0]   req_proc_ff, req_proc_in;
   logic                                is_request_ff, is_request_in;
   logic [bra_pkg::PROC_IDX_BITS-1:0]   scan_ff, scan_in;
   logic [bra_pkg::PROC_CNT_BITS-1:0]   pass_ff, pass_in;
   logic [bra_pkg::PROC_CNT_BITS-1:0]   done_ff, done_in;
   logic                                progress_ff, progress_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   bra_pkg::status_type                 rsp_status_ff, rsp_status_in;

   logic [bra_pkg::PROC_CNT_BITS-1:0]   np_eff;
   logic [bra_pkg::RES_CNT_BITS-1:0]    nr_eff;
   logic [bra_pkg::MAX_RES-1:0]         res_mask;
   logic [bra_pkg::PROC_IDX_BITS-1:0]   row_idx;
   logic [bra_pkg::PROC_IDX_BITS-1:0]   in_proc_idx;
   logic [bra_pkg::RES_IDX_BITS-1:0]    in_res_idx;
   logic                                in_proc_ok;
   logic                                in_res_ok;
   bra_pkg::unit_type                   in_amount;
   bra_pkg::work_vec_type               avail_ext;
   bra_pkg::work_vec_type               alloc_row_ext;
   bra_pkg::unit_ctl_type               unit_ctl;
   bra_pkg::unit_vec_type               lhs_vec;
   bra_pkg::work_vec_type               rhs_vec;
   bra_pkg::work_vec_type               acc_vec;
   bra_pkg::unit_vec_type               addend_vec;
   logic                                le_all;
   bra_pkg::work_vec_type               acc_out;
   logic                                fits;
   logic                                scan_last;
   logic [bra_pkg::PROC_CNT_BITS-1:0]   done_next;
   logic [bra_pkg::PROC_CNT_BITS-1:0]   pass_next;
   logic                                progress_next;
   logic                                finish_en;
   bra_pkg::status_type                 finish_status;
   logic                                scan_end;
   logic                                scan_safe;

   assign busy       = (state_ff != bra_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // Clamp configured counts to 1..max
   always_comb begin
      if (np_cfg_ff == '0) begin
         np_eff = bra_pkg::PROC_CNT_BITS'(1);
      end else if (int'(np_cfg_ff) > bra_pkg::MAX_PROCS) begin
         np_eff = bra_pkg::PROC_CNT_BITS'(bra_pkg::MAX_PROCS);
      end else begin
         np_eff = bra_pkg::PROC_CNT_BITS'(np_cfg_ff);
      end
      if (nr_cfg_ff == '0) begin
         nr_eff = bra_pkg::RES_CNT_BITS'(1);
      end else if (int'(nr_cfg_ff) > bra_pkg::MAX_RES) begin
         nr_eff = bra_pkg::RES_CNT_BITS'(bra_pkg::MAX_RES);
      end else begin
         nr_eff = bra_pkg::RES_CNT_BITS'(nr_cfg_ff);
      end
      for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
         res_mask[r] = (r < int'(nr_eff));
      end
   end

   // Decode input indexes
   assign in_proc_ok  = (int'(req_process) < bra_pkg::MAX_PROCS);
   assign in_res_ok   = (int'(req_resource) < bra_pkg::MAX_RES);
   assign in_proc_idx = bra_pkg::PROC_IDX_BITS'(req_process);
   assign in_res_idx  = bra_pkg::RES_IDX_BITS'(req_resource);
   assign in_amount   = bra_pkg::UNIT_BITS'(req_amount);

   // Table row under evaluation: scan pointer or requesting process
   assign row_idx = (state_ff == bra_pkg::S_SAFE) ? scan_ff
                                                  : bra_pkg::PROC_IDX_BITS'(req_proc_ff);

   always_comb begin
      for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
         avail_ext[r]     = bra_pkg::WORK_BITS'(avail_ff[r]);
         alloc_row_ext[r] = bra_pkg::WORK_BITS'(alloc_ff[row_idx][r]);
      end
   end

   // Drive the shared unit per state
   always_comb begin
      unit_ctl.cmp_sel = bra_pkg::CMP_LHS_RHS;
      unit_ctl.acc_sub = 1'b0;
      lhs_vec          = pending_ff;
      rhs_vec          = avail_ext;
      acc_vec          = avail_ext;
      addend_vec       = pending_ff;
      unique case (state_ff)
         bra_pkg::S_NEED: begin
            unit_ctl.cmp_sel = bra_pkg::CMP_LHS_NEED;
         end
         bra_pkg::S_APPLY_AV: begin
            unit_ctl.acc_sub = 1'b1;
         end
         bra_pkg::S_APPLY_AL: begin
            acc_vec = alloc_row_ext;
         end
         bra_pkg::S_SAFE: begin
            unit_ctl.cmp_sel = bra_pkg::CMP_NEED_RHS;
            rhs_vec          = work_ff;
            acc_vec          = work_ff;
            addend_vec       = alloc_ff[row_idx];
         end
         bra_pkg::S_UNDO_AL: begin
            unit_ctl.acc_sub = 1'b1;
            acc_vec          = alloc_row_ext;
         end
         default: begin
         end
      endcase
   end

   bra_vec_unit u_vec_unit (
      .ctl        (unit_ctl),
      .lane_mask  (res_mask),
      .max_row    (max_ff[row_idx]),
      .alloc_row  (alloc_ff[row_idx]),
      .lhs_vec    (lhs_vec),
      .rhs_vec    (rhs_vec),
      .acc_vec    (acc_vec),
      .addend_vec (addend_vec),
      .le_all     (le_all),
      .acc_out    (acc_out)
   );

   // Scan step bookkeeping
   assign fits          = !finished_ff[scan_ff] && le_all;
   assign scan_last     = (bra_pkg::PROC_CNT_BITS'(scan_ff) + bra_pkg::PROC_CNT_BITS'(1))
                          == np_eff;
   assign done_next     = fits ? done_ff + bra_pkg::PROC_CNT_BITS'(1) : done_ff;
   assign pass_next     = pass_ff + bra_pkg::PROC_CNT_BITS'(1);
   assign progress_next = progress_ff || fits;
   assign scan_safe     = (done_next == np_eff);
   assign scan_end      = scan_last &&
                          (scan_safe || !progress_next || (pass_next == np_eff));

   // Next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      np_cfg_in     = np_cfg_ff;
      nr_cfg_in     = nr_cfg_ff;
      avail_in      = avail_ff;
      max_in        = max_ff;
      alloc_in      = alloc_ff;
      pending_in    = pending_ff;
      work_in       = work_ff;
      finished_in   = finished_ff;
      req_proc_in   = req_proc_ff;
      is_request_in = is_request_ff;
      scan_in       = scan_ff;
      pass_in       = pass_ff;
      done_in       = done_ff;
      progress_in   = progress_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      finish_en     = 1'b0;
      finish_status = bra_pkg::ST_ACCEPTED;

      // Configuration writes
      if (csr_write_en) begin
         priority if (csr_index == bra_pkg::CSR_NUM_PROCS) begin
            np_cfg_in = csr_wdata;
         end else if (csr_index == bra_pkg::CSR_NUM_RES) begin
            nr_cfg_in = csr_wdata;
         end else begin
         end
      end

      unique case (state_ff)
         bra_pkg::S_IDLE: begin
            if (start) begin
               unique case (bra_pkg::action_type'(req_action))
                  bra_pkg::ACT_LOAD_AVAIL: begin
                     if (in_res_ok) avail_in[in_res_idx] = in_amount;
                     finish_en = 1'b1;
                  end
                  bra_pkg::ACT_LOAD_MAX: begin
                     if (in_proc_ok && in_res_ok) max_in[in_proc_idx][in_res_idx] = in_amount;
                     finish_en = 1'b1;
                  end
                  bra_pkg::ACT_LOAD_ALLOC: begin
                     if (in_proc_ok && in_res_ok) begin
                        alloc_in[in_proc_idx][in_res_idx] = in_amount;
                     end
                     finish_en = 1'b1;
                  end
                  bra_pkg::ACT_REQUEST: begin
                     if (in_res_ok) pending_in[in_res_idx] = in_amount;
                     if (req_last_element) begin
                        req_proc_in   = req_process;
                        is_request_in = 1'b1;
                        state_in      = bra_pkg::S_NEED;
                     end else begin
                        finish_en = 1'b1;
                     end
                  end
                  bra_pkg::ACT_SAFETY: begin
                     is_request_in = 1'b0;
                     state_in      = bra_pkg::S_INIT;
                  end
                  default: begin
                     finish_en = 1'b1;
                  end
               endcase
            end
         end
         bra_pkg::S_NEED: begin
            if ((int'(req_proc_ff) >= int'(np_eff)) || !le_all) begin
               finish_en     = 1'b1;
               finish_status = bra_pkg::ST_EXCEEDS;
            end else begin
               state_in = bra_pkg::S_AVAIL;
            end
         end
         bra_pkg::S_AVAIL: begin
            if (le_all) begin
               state_in = bra_pkg::S_APPLY_AV;
            end else begin
               finish_en     = 1'b1;
               finish_status = bra_pkg::ST_UNAVAIL;
            end
         end
         bra_pkg::S_APPLY_AV, bra_pkg::S_UNDO_AV: begin
            for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
               avail_in[r] = bra_pkg::UNIT_BITS'(acc_out[r]);
            end
            state_in = (state_ff == bra_pkg::S_APPLY_AV) ? bra_pkg::S_APPLY_AL
                                                         : bra_pkg::S_UNDO_AL;
         end
         bra_pkg::S_APPLY_AL: begin
            for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
               alloc_in[row_idx][r] = bra_pkg::UNIT_BITS'(acc_out[r]);
            end
            state_in = bra_pkg::S_INIT;
         end
         bra_pkg::S_UNDO_AL: begin
            for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
               alloc_in[row_idx][r] = bra_pkg::UNIT_BITS'(acc_out[r]);
            end
            finish_en     = 1'b1;
            finish_status = bra_pkg::ST_ROLLBACK;
         end
         bra_pkg::S_INIT: begin
            for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
               work_in[r] = res_mask[r] ? avail_ext[r] : '0;
            end
            finished_in = '0;
            scan_in     = '0;
            pass_in     = '0;
            done_in     = '0;
            progress_in = 1'b0;
            state_in    = bra_pkg::S_SAFE;
         end
         bra_pkg::S_SAFE: begin
            // Retire the scanned process if its need fits the work vector
            if (fits) begin
               work_in              = acc_out;
               finished_in[scan_ff] = 1'b1;
            end
            done_in = done_next;
            if (scan_end) begin
               if (is_request_ff) begin
                  if (scan_safe) begin
                     finish_en     = 1'b1;
                     finish_status = bra_pkg::ST_GRANTED;
                  end else begin
                     state_in = bra_pkg::S_UNDO_AV;
                  end
               end else begin
                  finish_en     = 1'b1;
                  finish_status = scan_safe ? bra_pkg::ST_SAFE : bra_pkg::ST_UNSAFE;
               end
            end else if (scan_last) begin
               // Advance to the next pass
               scan_in     = '0;
               pass_in     = pass_next;
               progress_in = 1'b0;
            end else begin
               scan_in     = scan_ff + bra_pkg::PROC_IDX_BITS'(1);
               progress_in = progress_next;
            end
         end
         default: begin
            state_in = bra_pkg::S_IDLE;
         end
      endcase

      // Emit the result and drop the pending request after evaluation
      if (finish_en) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = finish_status;
         state_in      = bra_pkg::S_IDLE;
         if (state_ff != bra_pkg::S_IDLE && is_request_ff) begin
            pending_in = '0;
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bra_pkg::S_IDLE;
         np_cfg_ff     <= bra_pkg::CFG_BITS'(bra_pkg::CFG_RESET);
         nr_cfg_ff     <= bra_pkg::CFG_BITS'(bra_pkg::CFG_RESET);
         avail_ff      <= '0;
         for (int p = 0; p < bra_pkg::MAX_PROCS; p++) begin
            max_ff[p]   <= '0;
            alloc_ff[p] <= '0;
         end
         pending_ff    <= '0;
         work_ff       <= '0;
         finished_ff   <= '0;
         req_proc_ff   <= '0;
         is_request_ff <= 1'b0;
         scan_ff       <= '0;
         pass_ff       <= '0;
         done_ff       <= '0;
         progress_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= bra_pkg::ST_ACCEPTED;
      end else begin
         state_ff      <= state_in;
         np_cfg_ff     <= np_cfg_in;
         nr_cfg_ff     <= nr_cfg_in;
         avail_ff      <= avail_in;
         max_ff        <= max_in;
         alloc_ff      <= alloc_in;
         pending_ff    <= pending_in;
         work_ff       <= work_in;
         finished_ff   <= finished_in;
         req_proc_ff   <= req_proc_in;
         is_request_ff <= is_request_in;
         scan_ff       <= scan_in;
         pass_ff       <= pass_in;
         done_ff       <= done_in;
         progress_ff   <= progress_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Pass counter stays below the process count, retired count never above it
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bra_pkg::S_SAFE) |-> ((pass_ff < np_eff) && (done_ff <= np_eff)))
      else $error("scan counters out of range");

   // Retired count tracks the finished flags
   a_done_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bra_pkg::S_SAFE) |-> ($countones(finished_ff) == int'(done_ff)))
      else $error("retired count disagrees with finished flags");

   // A safety check transfer starts an evaluation
   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (bra_pkg::action_type'(req_action) == bra_pkg::ACT_SAFETY))
      |=> busy)
      else $error("safety check did not start");

   // Pending vector is clear whenever a request outcome is reported
   a_pending_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_status_ff == bra_pkg::ST_GRANTED) ||
                        (rsp_status_ff == bra_pkg::ST_EXCEEDS) ||
                        (rsp_status_ff == bra_pkg::ST_UNAVAIL) ||
                        (rsp_status_ff == bra_pkg::ST_ROLLBACK)))
      |-> (pending_ff == '0))
      else $error("pending request not cleared after evaluation");

endmodule

FILE: rtl/core/bra_vec_unit.sv
module bra_vec_unit (
   input  bra_pkg::unit_ctl_type            ctl,
   input  logic [bra_pkg::MAX_RES-1:0]      lane_mask,
   input  bra_pkg::unit_vec_type            max_row,
   input  bra_pkg::unit_vec_type            alloc_row,
   input  bra_pkg::unit_vec_type            lhs_vec,
   input  bra_pkg::work_vec_type            rhs_vec,
   input  bra_pkg::work_vec_type            acc_vec,
   input  bra_pkg::unit_vec_type            addend_vec,
   output logic                             le_all,
   output bra_pkg::work_vec_type            acc_out
);

   bra_pkg::unit_vec_type need_v;
   bra_pkg::work_vec_type cmp_a;
   bra_pkg::work_vec_type cmp_b;

   // Need per lane: claim minus allocation, floored at zero
   always_comb begin
      for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
         need_v[r] = (max_row[r] > alloc_row[r]) ? (max_row[r] - alloc_row[r])
                                                 : '0;
      end
   end

   // Pick compare operands per lane
   always_comb begin
      for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
         unique case (ctl.cmp_sel)
            bra_pkg::CMP_LHS_RHS: begin
               cmp_a[r] = bra_pkg::WORK_BITS'(lhs_vec[r]);
               cmp_b[r] = rhs_vec[r];
            end
            bra_pkg::CMP_LHS_NEED: begin
               cmp_a[r] = bra_pkg::WORK_BITS'(lhs_vec[r]);
               cmp_b[r] = bra_pkg::WORK_BITS'(need_v[r]);
            end
            bra_pkg::CMP_NEED_RHS: begin
               cmp_a[r] = bra_pkg::WORK_BITS'(need_v[r]);
               cmp_b[r] = rhs_vec[r];
            end
            default: begin
               cmp_a[r] = '0;
               cmp_b[r] = '0;
            end
         endcase
      end
   end

   // All active lanes must satisfy a <= b
   always_comb begin
      le_all = 1'b1;
      for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
         if (lane_mask[r] && (cmp_a[r] > cmp_b[r])) begin
            le_all = 1'b0;
         end
      end
   end

   // Accumulate on active lanes, hold the rest
   always_comb begin
      for (int r = 0; r < bra_pkg::MAX_RES; r++) begin
         if (!lane_mask[r]) begin
            acc_out[r] = acc_vec[r];
         end else if (ctl.acc_sub) begin
            acc_out[r] = acc_vec[r] - bra_pkg::WORK_BITS'(addend_vec[r]);
         end else begin
            acc_out[r] = acc_vec[r] + bra_pkg::WORK_BITS'(addend_vec[r]);
         end
      end
   end

endmodule

FILE: test/bankers_resource_allocator_checker.sv
module bankers_resource_allocator_checker
   import bra_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [ACTION_BITS-1:0]    req_action,
   input  logic [PROC_FLD_BITS-1:0]  req_process,
   input  logic [RES_FLD_BITS-1:0]   req_resource,
   input  logic [AMOUNT_BITS-1:0]    req_amount,
   input  logic                      req_last_element,
   input  logic                      rsp_valid,
   input  logic [STATUS_BITS-1:0]    rsp_status,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the allocator tables and counts
   unit_type            avail_units [MAX_RES];
   unit_type            claim_tbl   [MAX_PROCS][MAX_RES];
   unit_type            held_tbl    [MAX_PROCS][MAX_RES];
   unit_type            pend_vec    [MAX_RES];
   logic [CFG_BITS-1:0] procs_cfg;
   logic [CFG_BITS-1:0] res_cfg;

   // Statuses owed by the block, oldest first
   status_type status_due [$];

   // Map a count register onto the range the tables support
   function automatic int clamp_cnt(logic [CFG_BITS-1:0] v, int top);
      if (v == 0) return 1;
      if (int'(v) > top) return top;
      return int'(v);
   endfunction

   // Remaining claim, zero when allocation is above the claim
   function automatic unit_type need_units(int p, int r);
      if (claim_tbl[p][r] > held_tbl[p][r]) return unit_type'(claim_tbl[p][r] - held_tbl[p][r]);
      return '0;
   endfunction

   // Repeated-pass scan: can every process in use run to completion?
   function automatic bit state_is_safe();
      int       np;
      int       nr;
      int       done;
      int       pass;
      int       p;
      int       r;
      bit       progress;
      bit       fits;
      work_type work [MAX_RES];
      bit       finished [MAX_PROCS];
      np = clamp_cnt(procs_cfg, MAX_PROCS);
      nr = clamp_cnt(res_cfg, MAX_RES);
      for (r = 0; r < MAX_RES; r++)
         work[r] = (r < nr) ? work_type'(avail_units[r]) : '0;
      for (p = 0; p < MAX_PROCS; p++)
         finished[p] = 1'b0;
      done     = 0;
      progress = 1'b1;
      for (pass = 0; pass < np && done < np && progress; pass++) begin
         progress = 1'b0;
         for (p = 0; p < np; p++) begin
            if (!finished[p]) begin
               fits = 1'b1;
               for (r = 0; r < nr; r++)
                  if (work_type'(need_units(p, r)) > work[r]) fits = 1'b0;
               if (fits) begin
                  for (r = 0; r < nr; r++)
                     work[r] = work[r] + work_type'(held_tbl[p][r]);
                  finished[p] = 1'b1;
                  done++;
                  progress = 1'b1;
               end
            end
         end
      end
      return done >= np;
   endfunction

   // Judge the gathered request of one process, keep it or roll it back
   function automatic status_type settle_request(int p);
      int np;
      int nr;
      int r;
      np = clamp_cnt(procs_cfg, MAX_PROCS);
      nr = clamp_cnt(res_cfg, MAX_RES);
      if (p >= np) return ST_EXCEEDS;
      for (r = 0; r < nr; r++)
         if (pend_vec[r] > need_units(p, r)) return ST_EXCEEDS;
      for (r = 0; r < nr; r++)
         if (pend_vec[r] > avail_units[r]) return ST_UNAVAIL;
      for (r = 0; r < nr; r++) begin
         avail_units[r]  = avail_units[r] - pend_vec[r];
         held_tbl[p][r]  = held_tbl[p][r] + pend_vec[r];
      end
      if (state_is_safe()) return ST_GRANTED;
      for (r = 0; r < nr; r++) begin
         avail_units[r]  = avail_units[r] + pend_vec[r];
         held_tbl[p][r]  = held_tbl[p][r] - pend_vec[r];
      end
      return ST_ROLLBACK;
   endfunction

   // Apply one accepted item to the shadow state and return its status
   function automatic status_type predict_status(logic [ACTION_BITS-1:0] act,
                                                 logic [PROC_FLD_BITS-1:0] p,
                                                 logic [RES_FLD_BITS-1:0] r,
                                                 logic [AMOUNT_BITS-1:0] amt,
                                                 logic last);
      status_type st;
      st = ST_ACCEPTED;
      case (act)
         ACT_LOAD_AVAIL: avail_units[r] = amt;
         ACT_LOAD_MAX:   claim_tbl[p][r] = amt;
         ACT_LOAD_ALLOC: held_tbl[p][r] = amt;
         ACT_REQUEST: begin
            pend_vec[r] = amt;
            if (last) begin
               st       = settle_request(int'(p));
               pend_vec = '{default: '0};
            end
         end
         ACT_SAFETY: st = state_is_safe() ? ST_SAFE : ST_UNSAFE;
         default: ;
      endcase
      return st;
   endfunction

   always @(posedge clock) begin : watch
      status_type want;
      if (reset) begin
         avail_units = '{default: '0};
         claim_tbl   = '{default: '0};
         held_tbl    = '{default: '0};
         pend_vec    = '{default: '0};
         procs_cfg   = CFG_BITS'(CFG_RESET);
         res_cfg     = CFG_BITS'(CFG_RESET);
         fail_count  = 0;
         status_due.delete();
      end else begin
         // Compare the result transfer with the oldest prediction
         if (rsp_valid) begin
            if (status_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected status, expected none, actual %0d", $time, rsp_status);
            end else begin
               want = status_due.pop_front();
               if (rsp_status !== want) begin
                  fail_count++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want, rsp_status);
               end
            end
         end
         // Track register writes
         if (csr_write_en) begin
            if (csr_index == CSR_NUM_PROCS) procs_cfg = csr_wdata;
            else if (csr_index == CSR_NUM_RES) res_cfg = csr_wdata;
         end
         // Predict on every command transfer
         if (start && !busy)
            status_due.push_back(predict_status(req_action, req_process, req_resource,
                                                req_amount, req_last_element));
      end
      pending_count = status_due.size();
   end

endmodule

FILE: test/tb_bankers_resource_allocator_core.sv
module tb_bankers_resource_allocator_core;
   import bra_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes the block ignores, and actions it does not decode
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI   = 2'd3;
   localparam logic [ACTION_BITS-1:0]    ACT_UNUSED_LO  = 3'd5;
   localparam logic [ACTION_BITS-1:0]    ACT_UNUSED_MID = 3'd6;
   localparam logic [ACTION_BITS-1:0]    ACT_UNUSED_HI  = 3'd7;

   localparam int RANDOM_ITEMS = 1400;
   localparam int CALM_TAIL    = 200;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [ACTION_BITS-1:0]    req_action;
   logic [PROC_FLD_BITS-1:0]  req_process;
   logic [RES_FLD_BITS-1:0]   req_resource;
   logic [AMOUNT_BITS-1:0]    req_amount;
   logic                      req_last_element;
   logic                      rsp_valid;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_wdata;
   int                        fail_count;
   int                        pending_count;

   int items_sent;
   int calm_from;

   bankers_resource_allocator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_process      (req_process),
      .req_resource     (req_resource),
      .req_amount       (req_amount),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   bankers_resource_allocator_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_process      (req_process),
      .req_resource     (req_resource),
      .req_amount       (req_amount),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("tb_bankers_resource_allocator_core NOT OK");
      $finish;
   end

   // Drop start for a random burst now and then, except in the tail
   task automatic idle_burst();
      int n;
      if (items_sent < calm_from && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 14);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one command and hold it until the transfer
   task automatic send_item(logic [ACTION_BITS-1:0] act, logic [PROC_FLD_BITS-1:0] p,
                            logic [RES_FLD_BITS-1:0] r, logic [AMOUNT_BITS-1:0] amt,
                            logic last);
      idle_burst();
      start            <= 1'b1;
      req_action       <= act;
      req_process      <= p;
      req_resource     <= r;
      req_amount       <= amt;
      req_last_element <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Stop issuing and wait until every status has come back
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write both counts, sometimes also a spare index
   task automatic apply_setting(logic [CFG_BITS-1:0] np, logic [CFG_BITS-1:0] nr);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_NUM_PROCS;
      csr_wdata    <= np;
      @(posedge clock);
      csr_index    <= CSR_NUM_RES;
      csr_wdata    <= nr;
      @(posedge clock);
      if ($urandom_range(0, 3) == 0) begin
         csr_index <= $urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI;
         csr_wdata <= CFG_BITS'($urandom);
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CFG_BITS-1:0] np_w;
      logic [CFG_BITS-1:0] nr_w;
      int                  eff_p;
      int                  eff_r;
      int                  p;
      int                  r;
      int                  kind;
      int                  claim;
      int                  stop_at;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= '0;
      req_process      <= '0;
      req_resource     <= '0;
      req_amount       <= '0;
      req_last_element <= 1'b0;
      csr_write_en     <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      items_sent       = 0;
      calm_from        = 1 << 30;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty tables, undecoded actions, extremes of amount
      send_item(ACT_SAFETY, 3'd0, 3'd0, 8'd0, 1'b0);
      send_item(ACT_UNUSED_LO, 3'd7, 3'd7, 8'd255, 1'b1);
      send_item(ACT_UNUSED_MID, 3'd0, 3'd0, 8'd0, 1'b0);
      send_item(ACT_UNUSED_HI, 3'd5, 3'd2, 8'd170, 1'b1);
      send_item(ACT_LOAD_AVAIL, 3'd0, 3'd7, 8'd255, 1'b0);
      send_item(ACT_LOAD_MAX, 3'd7, 3'd7, 8'd255, 1'b0);
      // allocation above the claim: need clamps at zero
      send_item(ACT_LOAD_ALLOC, 3'd0, 3'd1, 8'd255, 1'b0);
      // grant, then over the claim
      send_item(ACT_REQUEST, 3'd7, 3'd7, 8'd255, 1'b1);
      send_item(ACT_REQUEST, 3'd7, 3'd7, 8'd1, 1'b1);
      // within claim but not available
      send_item(ACT_LOAD_MAX, 3'd1, 3'd0, 8'd5, 1'b0);
      send_item(ACT_REQUEST, 3'd1, 3'd0, 8'd3, 1'b1);
      // unsafe after the tentative grant: roll back, then check the state
      send_item(ACT_LOAD_AVAIL, 3'd0, 3'd0, 8'd2, 1'b0);
      send_item(ACT_LOAD_MAX, 3'd2, 3'd0, 8'd4, 1'b0);
      send_item(ACT_LOAD_ALLOC, 3'd2, 3'd0, 8'd2, 1'b0);
      send_item(ACT_REQUEST, 3'd1, 3'd0, 8'd2, 1'b1);
      send_item(ACT_SAFETY, 3'd0, 3'd0, 8'd0, 1'b0);
      // element left pending by another process spoils the next request
      send_item(ACT_REQUEST, 3'd4, 3'd3, 8'd9, 1'b0);
      send_item(ACT_REQUEST, 3'd2, 3'd0, 8'd2, 1'b1);
      send_item(ACT_REQUEST, 3'd2, 3'd0, 8'd2, 1'b1);
      // counts out of range: zero acts as one, above the table as the maximum
      wait_idle();
      apply_setting(4'd0, 4'd15);
      send_item(ACT_REQUEST, 3'd3, 3'd0, 8'd0, 1'b1);
      send_item(ACT_SAFETY, 3'd0, 3'd0, 8'd0, 1'b0);
      wait_idle();
      apply_setting(4'd15, 4'd0);
      send_item(ACT_SAFETY, 3'd0, 3'd0, 8'd0, 1'b0);

      // Random phases: set counts, load a table set, then mixed traffic
      stop_at   = items_sent + RANDOM_ITEMS;
      calm_from = stop_at - CALM_TAIL;
      while (items_sent < stop_at) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       np_w = 4'd0;
            1:       np_w = CFG_BITS'($urandom_range(9, 15));
            2, 3:    np_w = 4'd8;
            default: np_w = CFG_BITS'($urandom_range(1, 4));
         endcase
         case ($urandom_range(0, 9))
            0:       nr_w = 4'd0;
            1:       nr_w = CFG_BITS'($urandom_range(9, 15));
            2, 3:    nr_w = 4'd8;
            default: nr_w = CFG_BITS'($urandom_range(1, 4));
         endcase
         apply_setting(np_w, nr_w);
         eff_p = (np_w == 0) ? 1 : (int'(np_w) > MAX_PROCS) ? MAX_PROCS : int'(np_w);
         eff_r = (nr_w == 0) ? 1 : (int'(nr_w) > MAX_RES) ? MAX_RES : int'(nr_w);

         // Load availability, claims and allocations within the counts in use
         for (r = 0; r < eff_r; r++)
            send_item(ACT_LOAD_AVAIL, 3'd0, RES_FLD_BITS'(r),
                      AMOUNT_BITS'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
         for (p = 0; p < eff_p; p++)
            for (r = 0; r < eff_r; r++) begin
               claim = $urandom_range(0, 6);
               send_item(ACT_LOAD_MAX, PROC_FLD_BITS'(p), RES_FLD_BITS'(r),
                         AMOUNT_BITS'(claim), 1'($urandom_range(0, 1)));
               if ($urandom_range(0, 9) == 0)
                  send_item(ACT_LOAD_ALLOC, PROC_FLD_BITS'(p), RES_FLD_BITS'(r),
                            AMOUNT_BITS'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
               else
                  send_item(ACT_LOAD_ALLOC, PROC_FLD_BITS'(p), RES_FLD_BITS'(r),
                            AMOUNT_BITS'($urandom_range(0, claim)),
                            1'($urandom_range(0, 1)));
            end

         repeat ($urandom_range(15, 40)) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
               // well-formed request over the resources in use
               p = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7) : $urandom_range(0, eff_p - 1);
               for (r = 0; r < eff_r; r++)
                  if (r == eff_r - 1 || $urandom_range(0, 3) != 0)
                     send_item(ACT_REQUEST, PROC_FLD_BITS'(p), RES_FLD_BITS'(r),
                               AMOUNT_BITS'($urandom_range(0, 3)), r == eff_r - 1);
            end else if (kind < 70) begin
               send_item(ACT_SAFETY, PROC_FLD_BITS'($urandom), RES_FLD_BITS'($urandom),
                         AMOUNT_BITS'($urandom), 1'($urandom));
            end else if (kind < 85) begin
               send_item(ACTION_BITS'($urandom_range(int'(ACT_LOAD_AVAIL),
                                                     int'(ACT_LOAD_ALLOC))),
                         PROC_FLD_BITS'($urandom), RES_FLD_BITS'($urandom),
                         AMOUNT_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, 6)),
                         1'($urandom_range(0, 1)));
            end else if (kind < 93) begin
               // broken request: random fields and amounts
               repeat ($urandom_range(1, 4))
                  send_item(ACT_REQUEST, PROC_FLD_BITS'($urandom), RES_FLD_BITS'($urandom),
                            AMOUNT_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               send_item($urandom_range(0, 2) == 0 ? ACT_UNUSED_LO :
                         $urandom_range(0, 1) ? ACT_UNUSED_MID : ACT_UNUSED_HI,
                         PROC_FLD_BITS'($urandom), RES_FLD_BITS'($urandom),
                         AMOUNT_BITS'($urandom), 1'($urandom));
            end
         end
      end

      // Drain the remaining statuses, then let the block settle
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_bankers_resource_allocator_core OK");
      else
         $display("tb_bankers_resource_allocator_core NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/bra_pkg.sv
rtl/core/bra_vec_unit.sv
rtl/core/bankers_resource_allocator_core.sv
test/bankers_resource_allocator_checker.sv
test/tb_bankers_resource_allocator_core.sv
